FILE: rtl/core/accel_tilt_angle_defines.svh
// Assertion macros used by the tilt angle top level.
`ifndef ACCEL_TILT_ANGLE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define ATA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt angle assertion failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define ATA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt angle assertion failed");

`endif

FILE: rtl/core/ata_pkg.sv
package ata_pkg;

  // Field widths.
  localparam int IN_W  = 16;
  localparam int OUT_W = 15;

  // Square root chain: remainder and partial root width, cell count, result width.
  localparam int SQ_W       = 49;
  localparam int SQRT_CELLS = 24;
  localparam int MAG_W      = 24;

  // CORDIC datapath widths and angle fraction bits.
  localparam int CW        = 28;
  localparam int ZW        = 28;
  localparam int ZFRAC     = 20;
  localparam int TABLE_LEN = 24;

  // Defaults for the top level parameters.
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // Axis select register codes: roll puts y over the magnitude, pitch puts x.
  typedef enum logic {
    AXIS_ROLL  = 1'b0,
    AXIS_PITCH = 1'b1
  } axis_t;

  // Data carried down the square root chain.
  typedef struct packed {
    logic            valid;
    logic [IN_W-1:0] num;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sq_t;

  // Data carried down the CORDIC chain.
  typedef struct packed {
    logic          valid;
    logic          zero;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
  } cordic_t;

  // Arctangent of 2^-idx in degrees, with ZFRAC fraction bits.
  function automatic logic [ZW-1:0] atan_deg(input int idx);
    logic [ZW-1:0] val;
    unique case (idx)
      0:       val = ZW'(47185920);
      1:       val = ZW'(27855475);
      2:       val = ZW'(14718068);
      3:       val = ZW'(7471121);
      4:       val = ZW'(3750058);
      5:       val = ZW'(1876857);
      6:       val = ZW'(938658);
      7:       val = ZW'(469357);
      8:       val = ZW'(234682);
      9:       val = ZW'(117342);
      10:      val = ZW'(58671);
      11:      val = ZW'(29335);
      12:      val = ZW'(14668);
      13:      val = ZW'(7334);
      14:      val = ZW'(3667);
      15:      val = ZW'(1833);
      16:      val = ZW'(917);
      17:      val = ZW'(458);
      18:      val = ZW'(229);
      19:      val = ZW'(115);
      20:      val = ZW'(57);
      21:      val = ZW'(29);
      22:      val = ZW'(14);
      23:      val = ZW'(7);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/ata_sqrt_cell.sv
module ata_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  ata_pkg::sq_t cell_in,
  output ata_pkg::sq_t cell_out
);

  localparam logic [ata_pkg::SQ_W-1:0] BIT = ata_pkg::SQ_W'(1) << BIT_POS;

  logic [ata_pkg::SQ_W:0] trial;
  logic                   take;
  ata_pkg::sq_t           cell_next;

  // One digit of the restoring square root: try root plus the current bit.
  always_comb begin
    trial     = {1'b0, cell_in.root} + {1'b0, BIT};
    take      = ({1'b0, cell_in.rem} >= trial);
    cell_next = cell_in;
    if (take) begin
      cell_next.rem  = cell_in.rem - trial[ata_pkg::SQ_W-1:0];
      cell_next.root = (cell_in.root >> 1) + BIT;
    end else begin
      cell_next.root = cell_in.root >> 1;
    end
  end

  // Hand the result to the next cell when the pipeline moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: rtl/core/ata_cordic_cell.sv
module ata_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ata_pkg::cordic_t cell_in,
  output ata_pkg::cordic_t cell_out
);

  localparam logic [ata_pkg::ZW-1:0] ANGLE = ata_pkg::atan_deg(SHIFT);

  logic [ata_pkg::CW-1:0] x_shr;
  logic [ata_pkg::CW-1:0] y_shr;
  ata_pkg::cordic_t       cell_next;

  // One vectoring rotation: drive y toward zero, accumulate the angle.
  always_comb begin
    x_shr     = ata_pkg::CW'($signed(cell_in.x) >>> SHIFT);
    y_shr     = ata_pkg::CW'($signed(cell_in.y) >>> SHIFT);
    cell_next = cell_in;
    if (!cell_in.y[ata_pkg::CW-1]) begin
      cell_next.x = cell_in.x + y_shr;
      cell_next.y = cell_in.y - x_shr;
      cell_next.z = cell_in.z + ANGLE;
    end else begin
      cell_next.x = cell_in.x - y_shr;
      cell_next.y = cell_in.y + x_shr;
      cell_next.z = cell_in.z - ANGLE;
    end
  end

  // Hand the result to the next cell when the pipeline moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: rtl/core/accel_tilt_angle.sv
// Registers from sample to angle: squares, root head, root cells, CORDIC cells, output.
// Throughput: one sample per cycle; every cell of the square root and CORDIC rows
// is a pipeline register, and the whole row advances unless the angle is stalled.
// Reset: rst is synchronous; it clears all valid bits and sets axis_select to roll.
`include "accel_tilt_angle_defines.svh"

module accel_tilt_angle #(
  parameter int CORDIC_STAGES   = ata_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic                         cfg_write_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [ata_pkg::IN_W-1:0] accel_x,
  input  logic signed [ata_pkg::IN_W-1:0] accel_y,
  input  logic signed [ata_pkg::IN_W-1:0] accel_z,
  output logic                         angle_valid,
  input  logic                         angle_stall,
  output logic signed [ata_pkg::OUT_W-1:0] tilt_angle
);

  localparam int RND_SHIFT = ata_pkg::ZFRAC - ANGLE_FRAC_BITS;
  localparam logic [ata_pkg::ZW-1:0] RND_HALF = ata_pkg::ZW'(1) << (RND_SHIFT - 1);
  localparam int SQ_W  = ata_pkg::SQ_W;
  localparam int MAG_W = ata_pkg::MAG_W;
  localparam int CW    = ata_pkg::CW;
  localparam int ZW    = ata_pkg::ZW;

  ata_pkg::axis_t axis_select;
  logic           en;

  // Square stage.
  logic                   sq0_valid;
  logic [ata_pkg::IN_W-1:0] sq0_num;
  logic [30:0]            sq0_aa;
  logic [30:0]            sq0_bb;
  logic signed [ata_pkg::IN_W-1:0] sel_num;
  logic signed [ata_pkg::IN_W-1:0] sel_a;
  logic signed [31:0]     prod_a;
  logic signed [31:0]     prod_b;
  logic [31:0]            sum_sq;

  ata_pkg::sq_t     sq_head;
  ata_pkg::sq_t     sq_tail;
  ata_pkg::cordic_t cordic_head;
  ata_pkg::cordic_t cordic_tail;
  ata_pkg::sq_t     sq_chain [ata_pkg::SQRT_CELLS+1];
  ata_pkg::cordic_t cordic_chain [CORDIC_STAGES+1];

  logic [ZW-1:0] z_abs;
  logic [ZW-1:0] z_rnd;
  logic [ZW-1:0] z_res;
  logic          zero_xfer;

  // The whole row advances unless a finished angle is held by the receiver.
  assign en           = !(angle_valid && angle_stall);
  assign sample_stall = !en;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select <= ata_pkg::AXIS_ROLL;
    end else if (cfg_write_en) begin
      axis_select <= ata_pkg::axis_t'(cfg_write_data);
    end
  end

  // Pick the numerator and the two magnitude axes, then square them.
  always_comb begin
    if (axis_select == ata_pkg::AXIS_PITCH) begin
      sel_num = accel_x;
      sel_a   = accel_y;
    end else begin
      sel_num = accel_y;
      sel_a   = accel_x;
    end
    prod_a = sel_a * sel_a;
    prod_b = accel_z * accel_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq0_valid <= 1'b0;
    end else if (en) begin
      sq0_valid <= sample_valid;
      sq0_num   <= sel_num;
      sq0_aa    <= prod_a[30:0];
      sq0_bb    <= prod_b[30:0];
    end
  end

  // Sum of squares, scaled by 2^16, loads the square root row.
  assign sum_sq = {1'b0, sq0_aa} + {1'b0, sq0_bb};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_head.valid <= 1'b0;
    end else if (en) begin
      sq_head.valid <= sq0_valid;
      sq_head.num   <= sq0_num;
      sq_head.rem   <= {1'b0, sum_sq, 16'b0};
      sq_head.root  <= '0;
    end
  end

  assign sq_chain[0] = sq_head;
  assign sq_tail     = sq_chain[ata_pkg::SQRT_CELLS];

  // Square root row: one result bit per cell, most significant first.
  for (genvar k = 0; k < ata_pkg::SQRT_CELLS; k++) begin : g_sqrt
    ata_sqrt_cell #(
      .BIT_POS(2 * (ata_pkg::SQRT_CELLS - 1 - k))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .cell_in (sq_chain[k]),
      .cell_out(sq_chain[k+1])
    );
  end

  // CORDIC start vector: x is the magnitude, y the numerator with 8 fraction bits.
  always_comb begin
    cordic_head.valid = sq_tail.valid;
    cordic_head.x     = {{(CW-MAG_W){1'b0}}, sq_tail.root[MAG_W-1:0]};
    cordic_head.y     = {{(CW-ata_pkg::IN_W-8){sq_tail.num[ata_pkg::IN_W-1]}},
                         sq_tail.num, 8'b0};
    cordic_head.z     = '0;
    cordic_head.zero  = (sq_tail.num == '0) && (sq_tail.root == '0);
  end

  assign cordic_chain[0] = cordic_head;
  assign cordic_tail     = cordic_chain[CORDIC_STAGES];

  // CORDIC row: one rotation per cell.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ata_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .cell_in (cordic_chain[i]),
      .cell_out(cordic_chain[i+1])
    );
  end

  // Round the angle to the output fraction, halves away from zero.
  always_comb begin
    z_abs = cordic_tail.z[ZW-1] ? (ZW'(0) - cordic_tail.z) : cordic_tail.z;
    z_rnd = (z_abs + RND_HALF) >> RND_SHIFT;
    if (cordic_tail.zero) begin
      z_res = '0;
    end else if (cordic_tail.z[ZW-1]) begin
      z_res = ZW'(0) - z_rnd;
    end else begin
      z_res = z_rnd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (en) begin
      angle_valid <= cordic_tail.valid;
      tilt_angle  <= z_res[ata_pkg::OUT_W-1:0];
    end
  end

  // A zero vector leaving the CORDIC row in a moving cycle.
  assign zero_xfer = en && cordic_tail.valid && cordic_tail.zero;

  // A sample with zero numerator and zero magnitude leaves as angle zero.
  `ATA_ASSERT_NEXT(a_zero_out, zero_xfer, angle_valid && (tilt_angle == '0))
  // The finished square root fits the magnitude width.
  `ATA_ASSERT_IMP(a_root_width, sq_tail.valid, sq_tail.root[SQ_W-1:MAG_W] == '0)
  // The square root remainder never exceeds twice the root.
  `ATA_ASSERT_IMP(a_root_rem, sq_tail.valid, sq_tail.rem <= {sq_tail.root[SQ_W-2:0], 1'b0})
  // Vectoring leaves x non-negative at the end of the CORDIC row.
  `ATA_ASSERT_IMP(a_x_positive, cordic_tail.valid, !cordic_tail.x[CW-1])

endmodule
